// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: payload types, codes and cell control.
package spq_pkg;

    localparam int unsigned FIELD_WIDTH = 32;
    localparam int unsigned COUNT_FIELD_WIDTH = 5;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } spq_action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } spq_status_t;

    typedef enum logic {
        REG_SMALLEST_FIRST = 1'b0
    } spq_reg_t;

    typedef struct packed {
        logic                           action;
        logic signed [FIELD_WIDTH-1:0]  push_value;
    } spq_in_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0]  popped_value;
        logic signed [FIELD_WIDTH-1:0]  top_value;
        logic                           top_valid;
        logic [COUNT_FIELD_WIDTH-1:0]   entry_count;
        logic [1:0]                     status;
    } spq_out_t;

    typedef struct packed {
        logic push_en;
        logic pop_en;
        logic keep;
        logic take_new;
    } spq_cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One queue cell: holds an entry, compares it with the pushed value, shifts on push or pop.
module spq_cell #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  spq_pkg::spq_cell_ctl_t        ctl,
    input  logic                          smallest_first,
    input  logic signed [VALUE_WIDTH-1:0] new_value,
    input  logic signed [VALUE_WIDTH-1:0] from_above,
    input  logic signed [VALUE_WIDTH-1:0] from_below,
    output logic signed [VALUE_WIDTH-1:0] entry,
    output logic                          beats
);
    import spq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] entry_reg;
    logic signed [VALUE_WIDTH-1:0] entry_next;

    assign beats = smallest_first ? (entry_reg < new_value) : (new_value < entry_reg);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.push_en) begin
            if (ctl.keep) begin
                entry_next = entry_reg;
            end else if (ctl.take_new) begin
                entry_next = new_value;
            end else begin
                entry_next = from_above;
            end
        end else if (ctl.pop_en) begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue top level: row of cells, count, result register and APB register.
//
// Usage: each s_ transaction is a push of push_value (action 0) or a pop (action 1).
// Every accepted transaction yields exactly one m_ transaction carrying the popped
// value, the new top entry with its valid flag, the entry count and a status.
// The best entry sits in cell 0 while the ordering is unchanged; a push inserts into the
// row of cells (every cell compares against the new value at once), a pop shifts the row
// toward cell 0.
// The result is registered and appears on m_ in the cycle after the input is accepted.
// Throughput: one transaction per cycle while the m_ side does not stall.
// A stalled m_ side holds the result in the output register; s_ready stays high only
// while that register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result and
// selects smallest-first ordering. Cell contents are not cleared.
// APB register 0 (address 0), bit 0: smallest_first.
module sorted_priority_queue_top #(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  spq_pkg::spq_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output spq_pkg::spq_out_t    m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                          smallest_first_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          m_valid_reg;
    spq_out_t                      m_data_reg;
    spq_out_t                      result;
    spq_status_t                   op_status;

    logic signed [VALUE_WIDTH-1:0] push_vw;
    logic signed [VALUE_WIDTH-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]           beats;
    logic [CAPACITY-1:0]           occupied;
    logic [CAPACITY-1:0]           keep;
    spq_cell_ctl_t                 ctl [CAPACITY];

    logic                          accept;
    logic                          is_pop;
    logic                          full;
    logic                          empty;
    logic                          do_push;
    logic                          do_pop;
    logic                          cfg_write;
    logic signed [VALUE_WIDTH-1:0] popped_vw;
    logic signed [VALUE_WIDTH-1:0] top_vw;
    logic signed [FIELD_WIDTH-1:0] popped_32;
    logic signed [FIELD_WIDTH-1:0] top_32;

    // value width conversion
    generate
        if (VALUE_WIDTH >= FIELD_WIDTH) begin : g_wide
            assign push_vw = VALUE_WIDTH'(s_data.push_value);
            assign popped_32 = popped_vw[FIELD_WIDTH-1:0];
            assign top_32 = top_vw[FIELD_WIDTH-1:0];
        end else begin : g_narrow
            assign push_vw = s_data.push_value[VALUE_WIDTH-1:0];
            assign popped_32 = {{(FIELD_WIDTH-VALUE_WIDTH){popped_vw[VALUE_WIDTH-1]}},
                                popped_vw};
            assign top_32 = {{(FIELD_WIDTH-VALUE_WIDTH){top_vw[VALUE_WIDTH-1]}}, top_vw};
        end
    endgenerate

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_data.action == ACT_POP);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign do_push = accept && !is_pop && !full;
    assign do_pop  = accept && is_pop && !empty;

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cells
            assign occupied[k] = (count_reg > CW'(k));
            assign keep[k] = occupied[k] && (&beats[k:0]);
            assign ctl[k].push_en = do_push;
            assign ctl[k].pop_en = do_pop;
            assign ctl[k].keep = keep[k];
            if (k == 0) begin : g_first
                assign ctl[k].take_new = !keep[k];
            end else begin : g_rest
                assign ctl[k].take_new = !keep[k] && keep[k-1];
            end

            logic signed [VALUE_WIDTH-1:0] above;
            logic signed [VALUE_WIDTH-1:0] below;
            if (k == 0) begin : g_above_top
                assign above = push_vw;
            end else begin : g_above_cell
                assign above = entries[k-1];
            end
            if (k == CAPACITY - 1) begin : g_below_end
                assign below = '0;
            end else begin : g_below_cell
                assign below = entries[k+1];
            end

            spq_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .aclk          (aclk),
                .ctl           (ctl[k]),
                .smallest_first(smallest_first_reg),
                .new_value     (push_vw),
                .from_above    (above),
                .from_below    (below),
                .entry         (entries[k]),
                .beats         (beats[k])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        popped_vw  = '0;
        top_vw     = '0;
        op_status  = STATUS_OK;
        if (!is_pop) begin
            if (full) begin
                top_vw = entries[0];
                op_status = STATUS_FULL;
            end else begin
                count_next = count_reg + CW'(1);
                top_vw = keep[0] ? entries[0] : push_vw;
            end
        end else begin
            if (empty) begin
                op_status = STATUS_EMPTY;
            end else begin
                count_next = count_reg - CW'(1);
                popped_vw = entries[0];
                top_vw = (count_reg > CW'(1)) ? entries[1] : '0;
            end
        end
    end

    always_comb begin
        result              = '0;
        result.popped_value = popped_32;
        result.top_value    = top_32;
        result.top_valid    = (count_next != '0);
        result.entry_count  = COUNT_FIELD_WIDTH'(count_next);
        result.status       = op_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smallest_first_reg <= 1'b1;
        end else if (cfg_write && (paddr[2] == REG_SMALLEST_FIRST)) begin
            smallest_first_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SMALLEST_FIRST) begin
            prdata = {31'd0, smallest_first_reg};
        end
    end

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
module spq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input spq_pkg::spq_out_t m_data,
    input logic              m_valid,
    input logic              m_ready
);
    import spq_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted transaction produced no result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_EMPTY) |->
            (!m_data.top_valid && m_data.popped_value == '0 && m_data.entry_count == '0))
        else $error("refused pop reported data");

    a_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.top_valid) |-> (m_data.top_value == '0))
        else $error("top value nonzero on empty queue");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_data (m_data),
    .m_valid(m_valid),
    .m_ready(m_ready)
);
